/* design/mcsw_pkg.sv */
// Shared types, constants and helper functions of the motor current slot block.
package mcsw_pkg;

	localparam int NumSlots   = 16;
	localparam int LostLimit  = 200;
	localparam int StaleLimit = 100;
	localparam int LostTop    = 255;
	localparam int StaleTop   = 127;

	// register byte addresses (64-bit register spacing)
	localparam logic [4:0] RegEnable = 5'd0;
	localparam logic [4:0] RegTypes  = 5'd8;
	localparam logic [4:0] RegPower  = 5'd16;

	// motor type current limits
	localparam logic [15:0] LimType0   = 16'd10000;
	localparam logic [15:0] LimType1   = 16'd16384;
	localparam logic [15:0] LimType2   = 16'd32760;
	localparam logic [15:0] LimType3   = 16'd29000;
	localparam logic [15:0] LimType4   = 16'd30000;
	localparam logic [15:0] LimUnknown = 16'd32767;

	localparam logic [16:0] KOne = 17'd65536;
	localparam logic [15:0] POne = 16'd32768;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_SET  = 2'd1,
		CMD_FB   = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLAMP,
		ST_MUL1,
		ST_MUL2,
		ST_FIN,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [15:0] enable;
		logic [47:0] types;
		logic [15:0] power;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic fb_wr;
		logic clamp;
		logic mul1;
		logic mul2;
		logic fin;
		logic scan;
		logic emit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic any;
		logic grp_end;
		logic last_grp;
	} dp_sts_t;

	function automatic logic [15:0] type_limit(input logic [2:0] t);
		logic [15:0] l;
		unique case (t)
			3'd0:    l = LimType0;
			3'd1:    l = LimType1;
			3'd2:    l = LimType2;
			3'd3:    l = LimType3;
			3'd4:    l = LimType4;
			default: l = LimUnknown;
		endcase
		return l;
	endfunction

	// Q16 thermal derate factor, one for types without a winding limit
	function automatic logic [16:0] derate_k(input logic [2:0] t, input logic [7:0] tc);
		logic [16:0] k;
		k = KOne;
		if (t == 3'd3) begin
			if (tc <= 8'd70) k = KOne;
			else if (tc >= 8'd80) k = 17'd0;
			else begin
				unique case (tc)
					8'd71:   k = 17'(65536 * 9 / 10);
					8'd72:   k = 17'(65536 * 8 / 10);
					8'd73:   k = 17'(65536 * 7 / 10);
					8'd74:   k = 17'(65536 * 6 / 10);
					8'd75:   k = 17'(65536 * 5 / 10);
					8'd76:   k = 17'(65536 * 4 / 10);
					8'd77:   k = 17'(65536 * 3 / 10);
					8'd78:   k = 17'(65536 * 2 / 10);
					default: k = 17'(65536 * 1 / 10);
				endcase
			end
		end else if (t == 3'd1 || t == 3'd4) begin
			if (tc <= 8'd87) k = KOne;
			else if (tc >= 8'd100) k = 17'd0;
			else begin
				unique case (tc)
					8'd88:   k = 17'(65536 * 24 / 25);
					8'd89:   k = 17'(65536 * 22 / 25);
					8'd90:   k = 17'(65536 * 20 / 25);
					8'd91:   k = 17'(65536 * 18 / 25);
					8'd92:   k = 17'(65536 * 16 / 25);
					8'd93:   k = 17'(65536 * 14 / 25);
					8'd94:   k = 17'(65536 * 12 / 25);
					8'd95:   k = 17'(65536 * 10 / 25);
					8'd96:   k = 17'(65536 * 8 / 25);
					8'd97:   k = 17'(65536 * 6 / 25);
					8'd98:   k = 17'(65536 * 4 / 25);
					default: k = 17'(65536 * 2 / 25);
				endcase
			end
		end
		return k;
	endfunction

endpackage

/* design/mcsw_if.sv */
// Command and result channel interfaces.
interface mcsw_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic [3:0]         slot;
	logic signed [16:0] requested_current;
	logic               send;
	logic [15:0]        power_scale;
	logic [7:0]         temperature;
	logic               deforce;

	modport source (output valid, cmd, slot, requested_current, send, power_scale,
		temperature, deforce, input ready);
	modport sink (input valid, cmd, slot, requested_current, send, power_scale,
		temperature, deforce, output ready);
endinterface

interface mcsw_rsp_if;
	logic               valid;
	logic               ready;
	logic               result_kind;
	logic signed [15:0] applied_current;
	logic               frame_bus;
	logic               frame_group;
	logic signed [15:0] frame_current_a;
	logic signed [15:0] frame_current_b;
	logic signed [15:0] frame_current_c;
	logic signed [15:0] frame_current_d;
	logic               last;

	modport source (output valid, result_kind, applied_current, frame_bus, frame_group,
		frame_current_a, frame_current_b, frame_current_c, frame_current_d, last,
		input ready);
	modport sink (input valid, result_kind, applied_current, frame_bus, frame_group,
		frame_current_a, frame_current_b, frame_current_c, frame_current_d, last,
		output ready);
endinterface

/* design/mcsw_ctrl.sv */
// Controller state machine: sequences set, feedback and tick scan.
module mcsw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         in_cmd,
	output logic               in_ready,
	input  mcsw_pkg::dp_sts_t  sts,
	output mcsw_pkg::dp_cmd_t  ctl
);

	mcsw_pkg::state_t state_q, state_d;

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mcsw_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			mcsw_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					priority case (in_cmd)
						mcsw_pkg::CMD_SET:  state_d = mcsw_pkg::ST_CLAMP;
						mcsw_pkg::CMD_TICK: state_d = mcsw_pkg::ST_SCAN;
						mcsw_pkg::CMD_FB:   ctl.fb_wr = 1'b1;
						default:            state_d = mcsw_pkg::ST_IDLE;
					endcase
				end
			end
			mcsw_pkg::ST_CLAMP: begin
				ctl.clamp = 1'b1;
				state_d   = mcsw_pkg::ST_MUL1;
			end
			mcsw_pkg::ST_MUL1: begin
				ctl.mul1 = 1'b1;
				state_d  = mcsw_pkg::ST_MUL2;
			end
			mcsw_pkg::ST_MUL2: begin
				ctl.mul2 = 1'b1;
				state_d  = mcsw_pkg::ST_FIN;
			end
			mcsw_pkg::ST_FIN: begin
				if (sts.out_free) begin
					ctl.fin = 1'b1;
					state_d = mcsw_pkg::ST_IDLE;
				end
			end
			mcsw_pkg::ST_SCAN: begin
				ctl.scan = 1'b1;
				if (sts.grp_end) state_d = mcsw_pkg::ST_EMIT;
			end
			mcsw_pkg::ST_EMIT: begin
				// skip empty groups, wait for room otherwise
				if (!sts.any || sts.out_free) begin
					ctl.emit = 1'b1;
					state_d  = sts.last_grp ? mcsw_pkg::ST_IDLE : mcsw_pkg::ST_SCAN;
				end
			end
			default: state_d = mcsw_pkg::ST_IDLE;
		endcase
	end

endmodule

/* design/mcsw_dp.sv */
// Datapath: slot state, current limiting arithmetic, scan walk and result register.
module mcsw_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  mcsw_pkg::cfg_t    cfg,
	input  mcsw_pkg::dp_cmd_t ctl,
	output mcsw_pkg::dp_sts_t sts,
	mcsw_cmd_if.sink          cmd_ch,
	mcsw_rsp_if.source        rsp_ch
);

	logic signed [15:0] cur_q   [mcsw_pkg::NumSlots];
	logic [6:0]         stale_q [mcsw_pkg::NumSlots];
	logic [7:0]         lost_q  [mcsw_pkg::NumSlots];
	logic [15:0]        mark_q;
	logic [7:0]         temp_q  [mcsw_pkg::NumSlots];

	// latched word
	logic [3:0]         slot_q;
	logic signed [16:0] req_q;
	logic               send_q;
	logic [15:0]        pscale_q;
	logic               dis_q;

	// arithmetic pipeline
	logic signed [16:0] c_q;
	logic [16:0]        k_q;
	logic signed [34:0] prod1_q;
	logic signed [33:0] prod2_q;

	// scan
	logic [3:0]         idx_q;
	logic [1:0]         grp_q;
	logic               any_q;
	logic signed [15:0] frm_q [4];

	// result register
	logic               ov_q;
	logic               okind_q, obus_q, ogrp_q, olast_q;
	logic signed [15:0] oapp_q;
	logic signed [15:0] ofa_q, ofb_q, ofc_q, ofd_q;

	logic [2:0]         typ;
	logic signed [16:0] lim_s, clamp_c, c2, c3;
	logic signed [34:0] p1_adj;
	logic signed [33:0] p2_adj;
	logic [15:0]        p_eff;
	logic signed [15:0] set_val;
	logic               set_store;
	logic               scan_en;
	logic               later_en;
	logic signed [15:0] scan_cur;
	logic               out_free;

	assign out_free = !ov_q || rsp_ch.ready;
	assign typ      = cfg.types[{slot_q, 1'b0} + {2'b00, slot_q} +: 3];

	// clamp to the type limit
	always_comb begin
		lim_s   = $signed({1'b0, mcsw_pkg::type_limit(typ)});
		clamp_c = req_q;
		if (req_q > lim_s) clamp_c = lim_s;
		else if (req_q < -lim_s) clamp_c = -lim_s;
	end

	// truncate toward zero after each scaling
	assign p1_adj = prod1_q[34] ? prod1_q + 35'sd65535 : prod1_q;
	assign c2     = 17'(p1_adj >>> 16);
	assign p2_adj = prod2_q[33] ? prod2_q + 34'sd32767 : prod2_q;
	assign c3     = 17'(p2_adj >>> 15);

	always_comb begin
		p_eff = mcsw_pkg::POne;
		if (cfg.power[slot_q]) p_eff = (pscale_q > mcsw_pkg::POne) ? mcsw_pkg::POne : pscale_q;
	end

	assign set_store = send_q && cfg.enable[slot_q];
	assign set_val   = (set_store && (mark_q[slot_q] || dis_q)) ? 16'sd0 : 16'(c3);

	// current value of the scanned slot after watchdog aging
	assign scan_en = cfg.enable[idx_q];
	always_comb begin
		scan_cur = cur_q[idx_q];
		if (dis_q) scan_cur = 16'sd0;
		else if (scan_en) begin
			if (lost_q[idx_q] > 8'(mcsw_pkg::LostLimit)) scan_cur = 16'sd0;
			else if (stale_q[idx_q] > 7'(mcsw_pkg::StaleLimit)) scan_cur = 16'sd0;
		end
	end

	always_comb begin
		unique case (grp_q)
			2'd0: later_en = |cfg.enable[15:4];
			2'd1: later_en = |cfg.enable[15:8];
			2'd2: later_en = |cfg.enable[15:12];
			default: later_en = 1'b0;
		endcase
	end

	// latch word and run arithmetic
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			slot_q   <= cmd_ch.slot;
			req_q    <= cmd_ch.requested_current;
			send_q   <= cmd_ch.send;
			pscale_q <= cmd_ch.power_scale;
			dis_q    <= cmd_ch.deforce;
		end
		if (ctl.clamp) begin
			c_q <= clamp_c;
			k_q <= mcsw_pkg::derate_k(typ, temp_q[slot_q]);
		end
		if (ctl.mul1) prod1_q <= c_q * $signed({1'b0, k_q});
		if (ctl.mul2) prod2_q <= c2 * $signed({1'b0, p_eff});
		if (ctl.scan) frm_q[idx_q[1:0]] <= scan_cur;
	end

	// slot state and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mcsw_pkg::NumSlots; i++) begin
				cur_q[i]   <= '0;
				stale_q[i] <= '0;
				lost_q[i]  <= '0;
				temp_q[i]  <= '0;
			end
			mark_q <= '0;
			idx_q  <= '0;
			grp_q  <= '0;
			any_q  <= 1'b0;
		end else begin
			if (ctl.load) begin
				idx_q <= '0;
				any_q <= 1'b0;
			end
			if (ctl.fb_wr) begin
				temp_q[cmd_ch.slot] <= cmd_ch.temperature;
				lost_q[cmd_ch.slot] <= '0;
				mark_q[cmd_ch.slot] <= 1'b0;
			end
			if (ctl.fin && set_store) begin
				cur_q[slot_q]   <= set_val;
				stale_q[slot_q] <= '0;
			end
			if (ctl.scan) begin
				idx_q <= idx_q + 4'd1;
				grp_q <= idx_q[3:2];
				if (dis_q || scan_en) any_q <= 1'b1;
				if (!dis_q && scan_en) begin
					cur_q[idx_q] <= scan_cur;
					if (lost_q[idx_q] > 8'(mcsw_pkg::LostLimit)) mark_q[idx_q] <= 1'b1;
					else begin
						if (lost_q[idx_q] != 8'(mcsw_pkg::LostTop))
							lost_q[idx_q] <= lost_q[idx_q] + 8'd1;
						if (stale_q[idx_q] <= 7'(mcsw_pkg::StaleLimit) &&
						    stale_q[idx_q] != 7'(mcsw_pkg::StaleTop))
							stale_q[idx_q] <= stale_q[idx_q] + 7'd1;
					end
				end
			end
			if (ctl.emit) any_q <= 1'b0;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (ctl.fin || (ctl.emit && any_q)) ov_q <= 1'b1;
		else if (rsp_ch.ready) ov_q <= 1'b0;
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (ctl.fin) begin
			okind_q <= 1'b0;
			oapp_q  <= set_val;
			obus_q  <= 1'b0;
			ogrp_q  <= 1'b0;
			ofa_q   <= '0;
			ofb_q   <= '0;
			ofc_q   <= '0;
			ofd_q   <= '0;
			olast_q <= 1'b1;
		end else if (ctl.emit && any_q) begin
			okind_q <= 1'b1;
			oapp_q  <= '0;
			obus_q  <= grp_q[1];
			ogrp_q  <= grp_q[0];
			ofa_q   <= frm_q[0];
			ofb_q   <= frm_q[1];
			ofc_q   <= frm_q[2];
			ofd_q   <= frm_q[3];
			olast_q <= dis_q ? (grp_q == 2'd3) : !later_en;
		end
	end

	assign rsp_ch.valid           = ov_q;
	assign rsp_ch.result_kind     = okind_q;
	assign rsp_ch.applied_current = oapp_q;
	assign rsp_ch.frame_bus       = obus_q;
	assign rsp_ch.frame_group     = ogrp_q;
	assign rsp_ch.frame_current_a = ofa_q;
	assign rsp_ch.frame_current_b = ofb_q;
	assign rsp_ch.frame_current_c = ofc_q;
	assign rsp_ch.frame_current_d = ofd_q;
	assign rsp_ch.last            = olast_q;

	assign sts.out_free = out_free;
	assign sts.any      = any_q;
	assign sts.grp_end  = (idx_q[1:0] == 2'd3);
	assign sts.last_grp = (grp_q == 2'd3);

endmodule

/* design/motor_current_slots_with_watchdog_unit.sv */
// Set current: one word at a time through the clamp, derate multiply and power
// multiply steps of the shared datapath, then a finish step that writes the result.
// Feedback: taken in the accepting cycle, no result. Tick: the scan walk takes one slot
// per cycle over the 16 slots, and after each group of four a group with content waits for room to emit.
// The result register lets the next word start while a result waits to be taken.
// Reset (arst_n low) clears all slot state, counters and configuration to zero at once.
module motor_current_slots_with_watchdog_unit (
	input  logic        clk,
	input  logic        arst_n,
	mcsw_cmd_if.sink    cmd_ch,
	mcsw_rsp_if.source  rsp_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	mcsw_pkg::cfg_t    cfg_q;
	mcsw_pkg::dp_cmd_t ctl;
	mcsw_pkg::dp_sts_t sts;
	logic              ctl_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cfg_q <= '0;
		else if (psel && penable && pwrite) begin
			unique case (paddr)
				mcsw_pkg::RegEnable: cfg_q.enable <= pwdata[15:0];
				mcsw_pkg::RegTypes:  cfg_q.types  <= pwdata[47:0];
				mcsw_pkg::RegPower:  cfg_q.power  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (paddr)
			mcsw_pkg::RegEnable: prdata = {48'd0, cfg_q.enable};
			mcsw_pkg::RegTypes:  prdata = {16'd0, cfg_q.types};
			mcsw_pkg::RegPower:  prdata = {48'd0, cfg_q.power};
			default:             prdata = '0;
		endcase
	end
	assign pready = 1'b1;

	// take a word whenever the controller is idle
	assign cmd_ch.ready = ctl_ready;

	mcsw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd_ch.valid),
		.in_cmd   (cmd_ch.cmd),
		.in_ready (ctl_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	mcsw_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.ctl    (ctl),
		.sts    (sts),
		.cmd_ch (cmd_ch),
		.rsp_ch (rsp_ch)
	);

	// a reply is always the only result of its word
	a_reply_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ch.valid && !rsp_ch.result_kind |-> rsp_ch.last)
		else $error("reply without last");

	// a reply carries no frame content
	a_reply_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ch.valid && !rsp_ch.result_kind |->
		rsp_ch.frame_current_a == 16'sd0 && !rsp_ch.frame_bus && !rsp_ch.frame_group)
		else $error("reply with frame data");

	// a new word is only taken when the controller is idle
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_ready |-> !ctl.scan && !ctl.emit && !ctl.fin)
		else $error("word taken while busy");

endmodule
